### src/brtp_pkg.sv
// Shared types and codes for the base relocation table parser.
package brtp_pkg;

    localparam logic [1:0] KIND_FIXUP = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_BSIZE = 2'd2;
    localparam logic [1:0] KIND_BTYPE = 2'd3;

    localparam logic [3:0] TYPE_ABS     = 4'd0;
    localparam logic [3:0] TYPE_HIGH    = 4'd1;
    localparam logic [3:0] TYPE_LOW     = 4'd2;
    localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
    localparam logic [3:0] TYPE_DIR64   = 4'd10;

    localparam int OFFSET_W = 12;

    // Classified operation handed from the parser to the address stage
    typedef struct packed {
        logic [1:0]          kind;
        logic [31:0]         page;
        logic [OFFSET_W-1:0] offset;
        logic [3:0]          rtype;
    } t_op;

    localparam int OP_W = $bits(t_op);

endpackage

### src/base_reloc_table_parser.sv
// Top level of the base relocation table parser: registers, parser, queue, address stage.
//
//  channel   dir  handshake             payload
//  s (words) in   i_s_tvalid/o_s_tready tdata: table_word; tuser: new_table
//  m (fixes) out  o_m_tvalid/i_m_tready tdata: fixup_address, fixup_type; tuser: result_kind
//  apb cfg   in   psel/penable/pready   0x0 load_base, 0x8 table_size
//
//  One word is taken every cycle while the queue has room; a result passes
//  from the parser through the queue into the register of the 64-bit address add.
//  Reset is synchronous and clears the walk state and the queue.
//  A stalled output holds its register; the queue soaks up QUEUE_DEPTH
//  results before the word input stalls.
module base_reloc_table_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] table_word
    input  logic        i_s_tuser,   // [0] new_table
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [63:0] fixup_address, [67:64] fixup_type, [71:68] zero
    output logic [1:0]  o_m_tuser,   // [1:0] result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0]   r_load_base;
    logic [31:0]   r_table_size;
    logic          cfg_wr;
    logic          in_accept;
    logic          push;
    brtp_pkg::t_op push_op;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [brtp_pkg::OP_W-1:0] q_rdata;
    brtp_pkg::t_op q_op;
    logic [1:0]    out_kind;
    logic [63:0]   out_addr;
    logic [3:0]    out_type;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[3] ? {32'd0, r_table_size} : r_load_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base  <= '0;
            r_table_size <= '0;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_table_size <= pwdata[31:0];
            end else begin
                r_load_base <= pwdata;
            end
        end
    end

    assign o_s_tready = !q_full;
    assign in_accept  = i_s_tvalid && !q_full;

    brtp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_word       (i_s_tdata),
        .i_new_table  (i_s_tuser),
        .i_table_size (r_table_size),
        .o_push       (push),
        .o_op         (push_op)
    );

    brtp_fifo #(
        .WIDTH (brtp_pkg::OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    assign q_op = brtp_pkg::t_op'(q_rdata);

    brtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_base (r_load_base),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_pop       (q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (out_kind),
        .o_addr      (out_addr),
        .o_type      (out_type)
    );

    assign o_m_tdata = {4'd0, out_type, out_addr};
    assign o_m_tuser = out_kind;

endmodule

### src/brtp_fifo.sv
// Small register queue between the parser and the address stage.
module brtp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

### src/brtp_front.sv
// Word parser: walks block headers and entries, classifies each word.
module brtp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [15:0]         i_word,
    input  logic                i_new_table,
    input  logic [31:0]         i_table_size,
    output logic                o_push,
    output brtp_pkg::t_op       o_op
);

    localparam logic [2:0] PH_ADDR_LO = 3'd0;
    localparam logic [2:0] PH_ADDR_HI = 3'd1;
    localparam logic [2:0] PH_SIZE_LO = 3'd2;
    localparam logic [2:0] PH_SIZE_HI = 3'd3;
    localparam logic [2:0] PH_ENTRY   = 3'd4;
    localparam logic [2:0] PH_STOP    = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_page, n_page;
    logic [31:0] r_bbytes, n_bbytes;
    logic [30:0] r_left, n_left;
    logic [31:0] r_bproc, n_bproc;

    logic [2:0]  phase;
    logic [31:0] page;
    logic [31:0] bbytes;
    logic [30:0] left;
    logic [31:0] bproc;
    logic [31:0] size_full;
    logic [30:0] left_init;
    logic [30:0] left_dec;
    logic [31:0] bproc_done;
    logic [3:0]  rtype;
    logic        push;
    brtp_pkg::t_op op;

    // new_table restarts the walk before this word is parsed
    assign phase  = i_new_table ? PH_ADDR_LO : r_phase;
    assign page   = i_new_table ? '0 : r_page;
    assign bbytes = i_new_table ? '0 : r_bbytes;
    assign left   = i_new_table ? '0 : r_left;
    assign bproc  = i_new_table ? '0 : r_bproc;

    assign size_full  = {i_word, bbytes[15:0]};
    assign left_init  = size_full[31:1] - 31'd4;
    assign left_dec   = left - 31'd1;
    assign bproc_done = bproc + ((phase == PH_SIZE_HI) ? size_full : bbytes);
    assign rtype      = i_word[15:12];

    always_comb begin
        n_phase  = phase;
        n_page   = page;
        n_bbytes = bbytes;
        n_left   = left;
        n_bproc  = bproc;
        push     = 1'b0;
        op       = '0;
        case (phase)
            PH_ADDR_LO: begin
                if (bproc >= i_table_size) begin
                    n_phase = PH_STOP;
                    push    = 1'b1;
                    op.kind = brtp_pkg::KIND_END;
                end else begin
                    n_page  = {16'd0, i_word};
                    n_phase = PH_ADDR_HI;
                end
            end
            PH_ADDR_HI: begin
                n_page  = {i_word, page[15:0]};
                n_phase = PH_SIZE_LO;
            end
            PH_SIZE_LO: begin
                n_bbytes = {16'd0, i_word};
                n_phase  = PH_SIZE_HI;
            end
            PH_SIZE_HI: begin
                n_bbytes = size_full;
                if (size_full == '0) begin
                    n_phase = PH_STOP;
                    push    = 1'b1;
                    op.kind = brtp_pkg::KIND_END;
                end else if (size_full < 32'd8 || size_full[0]) begin
                    n_phase = PH_STOP;
                    push    = 1'b1;
                    op.kind = brtp_pkg::KIND_BSIZE;
                end else begin
                    n_left = left_init;
                    if (left_init == '0) begin
                        // header-only block: close it at once
                        n_bproc = bproc_done;
                        n_phase = PH_ADDR_LO;
                    end else begin
                        n_phase = PH_ENTRY;
                    end
                end
            end
            PH_ENTRY: begin
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_bproc = bproc_done;
                    n_phase = PH_ADDR_LO;
                end
                if (rtype != brtp_pkg::TYPE_ABS) begin
                    push      = 1'b1;
                    op.page   = page;
                    op.offset = i_word[brtp_pkg::OFFSET_W-1:0];
                    op.rtype  = rtype;
                    if (rtype == brtp_pkg::TYPE_HIGH || rtype == brtp_pkg::TYPE_LOW ||
                        rtype == brtp_pkg::TYPE_HIGHLOW || rtype == brtp_pkg::TYPE_DIR64) begin
                        op.kind = brtp_pkg::KIND_FIXUP;
                    end else begin
                        op.kind = brtp_pkg::KIND_BTYPE;
                        n_phase = PH_STOP;
                    end
                end
            end
            default: begin
                // stopped: drop words until a new table
            end
        endcase
    end

    assign o_push = i_accept && push;
    assign o_op   = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ADDR_LO;
            r_page   <= '0;
            r_bbytes <= '0;
            r_left   <= '0;
            r_bproc  <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_page   <= n_page;
            r_bbytes <= n_bbytes;
            r_left   <= n_left;
            r_bproc  <= n_bproc;
        end
    end

endmodule

### src/brtp_back.sv
// Address stage: forms the fixup address and holds the result for transfer.
module brtp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [63:0]   i_load_base,
    input  logic          i_op_valid,
    input  brtp_pkg::t_op i_op,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [63:0]   o_addr,
    output logic [3:0]    o_type
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [63:0] r_addr, n_addr;
    logic [3:0]  r_type;
    logic        load;
    logic        has_addr;

    assign load     = i_op_valid && (!r_valid || i_ready);
    assign o_pop    = load;
    assign has_addr = (i_op.kind == brtp_pkg::KIND_FIXUP) ||
                      (i_op.kind == brtp_pkg::KIND_BTYPE);
    assign n_addr   = i_load_base + {32'd0, i_op.page} +
                      {{(64 - brtp_pkg::OFFSET_W){1'b0}}, i_op.offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_op.kind;
            r_addr <= has_addr ? n_addr : '0;
            r_type <= has_addr ? i_op.rtype : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_addr  = r_addr;
    assign o_type  = r_type;

endmodule
